// File: rtl/icalc_pkg.sv
// icalc_pkg: opcodes, status codes and sequencer states for the integer calculator
// no dependencies
`timescale 1ns / 1ps

package icalc_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;
  localparam logic [2:0] OP_FACT = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIV0    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_WAIT,
    S_DIV_WAIT,
    S_SQRT_WAIT,
    S_POW_TEST,
    S_POW_ACC,
    S_POW_SQ,
    S_FACT_TEST,
    S_FACT_MUL,
    S_DONE
  } state_t;

endpackage

// File: rtl/icalc_if.sv
// icalc_in_if and icalc_out_if: valid/ready channels for operations and results
// uses no package
`timescale 1ns / 1ps

interface icalc_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic signed [W-1:0] operand_a;
  logic signed [W-1:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface icalc_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result;
  logic [1:0]          status;

  modport source (output valid, result, status, input ready);
  modport sink   (input valid, result, status, output ready);
endinterface

// File: rtl/icalc_mul.sv
// icalc_mul: shift-add multiplier, one multiplier bit per cycle, product mod 2^W
// no package dependencies
`timescale 1ns / 1ps

module icalc_mul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic         done,
  output logic [W-1:0] product
);

  logic         busy;
  logic [W-1:0] mcand;
  logic [W-1:0] mplier;
  logic [W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= '0;
        mcand  <= x;
        mplier <= y;
      end else if (busy) begin
        if (mplier == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= {mcand[W-2:0], 1'b0};
          mplier <= {1'b0, mplier[W-1:1]};
        end
      end
    end
  end

  assign product = acc;

endmodule

// File: rtl/icalc_div.sv
// icalc_div: restoring unsigned divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps

module icalc_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quot
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  d;
  logic [W-1:0]  q;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem, q[W-1]};
  assign diff    = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        d    <= den;
        q    <= num;
      end else if (busy) begin
        if (cnt == CW'(W)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CW'(1);
          if (!diff[W]) begin
            rem <= diff[W-1:0];
            q   <= {q[W-2:0], 1'b1};
          end else begin
            rem <= shifted[W-1:0];
            q   <= {q[W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign quot = q;

endmodule

// File: rtl/icalc_sqrt.sv
// icalc_sqrt: digit-by-digit floor square root, one root bit per cycle
// no package dependencies
`timescale 1ns / 1ps

module icalc_sqrt #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] radicand,
  output logic         done,
  output logic [W-1:0] root
);

  localparam int NP = (W + 1) / 2;
  localparam int RW = NP + 3;
  localparam int CW = $clog2(NP + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [2*NP-1:0] val;
  logic [RW-1:0] rem;
  logic [NP-1:0] rt;
  logic [RW-1:0] shifted;
  logic [RW-1:0] trial;
  logic [RW-1:0] diff;
  logic          fits;

  assign shifted = {rem[RW-3:0], val[2*NP-1 -: 2]};
  assign trial   = RW'({rt, 2'b01});
  assign fits    = shifted >= trial;
  assign diff    = shifted - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        rt   <= '0;
        val  <= (2*NP)'(radicand);
      end else if (busy) begin
        if (cnt == CW'(NP)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CW'(1);
          val <= {val[2*NP-3:0], 2'b00};
          if (fits) begin
            rem <= diff;
            rt  <= {rt[NP-2:0], 1'b1};
          end else begin
            rem <= shifted;
            rt  <= {rt[NP-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign root = W'(rt);

endmodule

// File: rtl/integer_calculator_alu.sv
// integer_calculator_alu: top level, sequencer around the serial multiplier, divider and root
// depends on icalc_pkg, icalc_if, icalc_mul, icalc_div, icalc_sqrt
`timescale 1ns / 1ps

// One operation at a time. Add and subtract register their result on transfer and then
// go to the done state. Multiply time grows with the bit position of the top set bit of
// operand_b, since the shared shift-add multiplier retires one multiplier bit per cycle.
// Divide runs on the restoring divider, square root on the digit-by-digit root unit. Power
// does one or two serial multiplies per exponent bit up to the top set bit; factorial does
// one serial multiply per factor until the factor passes operand_a or the product wraps to
// zero, at most about W+2 factors. A finished result waits in an output register while
// the next operation is taken in.
module integer_calculator_alu
  import icalc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  icalc_in_if.sink     in_ch,
  icalc_out_if.source  out_ch
);

  localparam int W = DATA_WIDTH;

  state_t state, state_next;

  logic [W-1:0] acc, base, expo, idx, lim;
  logic [W-1:0] res;
  logic [1:0]   stat;
  logic         div_neg;

  logic         mul_go, div_go, sqrt_go;
  logic [W-1:0] mul_x, mul_y, div_n, div_d, sqrt_v;
  logic         mul_done, div_done, sqrt_done;
  logic [W-1:0] mul_p, div_q, sqrt_r;

  logic         ov;
  logic [W-1:0] out_res;
  logic [1:0]   out_stat;
  logic         in_fire, out_free;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !ov || out_ch.ready;

  icalc_mul #(.W(W)) u_mul (
    .clk, .rst, .start(mul_go), .x(mul_x), .y(mul_y), .done(mul_done), .product(mul_p)
  );

  icalc_div #(.W(W)) u_div (
    .clk, .rst, .start(div_go), .num(div_n), .den(div_d), .done(div_done), .quot(div_q)
  );

  icalc_sqrt #(.W(W)) u_sqrt (
    .clk, .rst, .start(sqrt_go), .radicand(sqrt_v), .done(sqrt_done), .root(sqrt_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.mode)
            OP_MUL:  state_next = S_MUL_WAIT;
            OP_DIV:  state_next = (in_ch.operand_b == '0) ? S_DONE : S_DIV_WAIT;
            OP_POW:  state_next = in_ch.operand_b[W-1] ? S_DONE : S_POW_TEST;
            OP_SQRT: state_next = in_ch.operand_a[W-1] ? S_DONE : S_SQRT_WAIT;
            OP_FACT: state_next = in_ch.operand_a[W-1] ? S_DONE : S_FACT_TEST;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_MUL_WAIT:  if (mul_done) state_next = S_DONE;
      S_DIV_WAIT:  if (div_done) state_next = S_DONE;
      S_SQRT_WAIT: if (sqrt_done) state_next = S_DONE;
      S_POW_TEST: begin
        if (expo == '0) begin
          state_next = S_DONE;
        end else if (expo[0]) begin
          state_next = S_POW_ACC;
        end else begin
          state_next = S_POW_SQ;
        end
      end
      S_POW_ACC: if (mul_done) state_next = S_POW_SQ;
      S_POW_SQ:  if (mul_done) state_next = S_POW_TEST;
      S_FACT_TEST: begin
        if (idx > lim || acc == '0) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FACT_MUL;
        end
      end
      S_FACT_MUL: if (mul_done) state_next = S_FACT_TEST;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go  <= 1'b0;
      div_go  <= 1'b0;
      sqrt_go <= 1'b0;
      ov      <= 1'b0;
    end else begin
      mul_go  <= 1'b0;
      div_go  <= 1'b0;
      sqrt_go <= 1'b0;
      if (ov && out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res  <= '0;
            stat <= ST_OK;
            case (in_ch.mode)
              OP_ADD: res <= in_ch.operand_a + in_ch.operand_b;
              OP_SUB: res <= in_ch.operand_a - in_ch.operand_b;
              OP_MUL: begin
                mul_x  <= in_ch.operand_a;
                mul_y  <= in_ch.operand_b;
                mul_go <= 1'b1;
              end
              OP_DIV: begin
                if (in_ch.operand_b == '0) begin
                  stat <= ST_DIV0;
                end else begin
                  div_n   <= in_ch.operand_a[W-1] ? W'(-in_ch.operand_a) : in_ch.operand_a;
                  div_d   <= in_ch.operand_b[W-1] ? W'(-in_ch.operand_b) : in_ch.operand_b;
                  div_neg <= in_ch.operand_a[W-1] ^ in_ch.operand_b[W-1];
                  div_go  <= 1'b1;
                end
              end
              OP_POW: begin
                if (in_ch.operand_b[W-1]) begin
                  if (in_ch.operand_a == '0) begin
                    stat <= ST_INVALID;
                  end else if (in_ch.operand_a == W'(1)) begin
                    res <= W'(1);
                  end else if (in_ch.operand_a == '1) begin
                    res <= in_ch.operand_b[0] ? '1 : W'(1);
                  end
                end else begin
                  acc  <= W'(1);
                  base <= in_ch.operand_a;
                  expo <= in_ch.operand_b;
                end
              end
              OP_SQRT: begin
                if (in_ch.operand_a[W-1]) begin
                  stat <= ST_INVALID;
                end else begin
                  sqrt_v  <= in_ch.operand_a;
                  sqrt_go <= 1'b1;
                end
              end
              OP_FACT: begin
                if (in_ch.operand_a[W-1]) begin
                  stat <= ST_INVALID;
                end else begin
                  acc <= W'(1);
                  idx <= W'(2);
                  lim <= in_ch.operand_a;
                end
              end
              default: stat <= ST_INVALID;
            endcase
          end
        end
        S_MUL_WAIT:  if (mul_done) res <= mul_p;
        S_DIV_WAIT:  if (div_done) res <= div_neg ? W'(-div_q) : div_q;
        S_SQRT_WAIT: if (sqrt_done) res <= sqrt_r;
        S_POW_TEST: begin
          if (expo == '0) begin
            res <= acc;
          end else begin
            mul_x  <= expo[0] ? acc : base;
            mul_y  <= base;
            mul_go <= 1'b1;
          end
        end
        S_POW_ACC: begin
          if (mul_done) begin
            acc    <= mul_p;
            mul_x  <= base;
            mul_y  <= base;
            mul_go <= 1'b1;
          end
        end
        S_POW_SQ: begin
          if (mul_done) begin
            base <= mul_p;
            expo <= {1'b0, expo[W-1:1]};
          end
        end
        S_FACT_TEST: begin
          if (idx > lim || acc == '0) begin
            res <= acc;
          end else begin
            mul_x  <= acc;
            mul_y  <= idx;
            mul_go <= 1'b1;
          end
        end
        S_FACT_MUL: begin
          if (mul_done) begin
            acc <= mul_p;
            idx <= idx + W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            ov       <= 1'b1;
            out_res  <= res;
            out_stat <= stat;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid  = ov;
  assign out_ch.result = out_res;
  assign out_ch.status = out_stat;

endmodule
